FILE: hw/rtl/named_timer_table_assert.svh
// Assertion macros for the checker file of the timer table.
`ifndef NAMED_TIMER_TABLE_ASSERT_SVH
`define NAMED_TIMER_TABLE_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define NTT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle that implies a condition in the next cycle.
`define NTT_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error(msg);

`endif

FILE: hw/rtl/ntt_pkg.sv
`timescale 1ns / 1ps

package ntt_pkg;

	// Request kinds.
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_CHECK = 1'b1;

	// Start outcomes.
	localparam logic [1:0] STATUS_CREATED   = 2'd0;
	localparam logic [1:0] STATUS_FULL      = 2'd1;
	localparam logic [1:0] STATUS_DUPLICATE = 2'd2;

	// Limit register width and reset value.
	localparam int unsigned LIMIT_BITS = 5;
	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 5'd10;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} ntt_state_t;

endpackage

FILE: hw/rtl/named_timer_table.sv
// Channel     | Signals                                         | Transaction
// ------------+-------------------------------------------------+---------------------------
// request     | start, busy, kind, timer_key, timer_duration,   | start high, busy low
//             | current_time_ns                                 |
// result      | result_valid, start_status, key_found,          | result_valid high, one cycle
//             | timer_elapsed, timer_expired                    |
// config      | cfg_valid, cfg_ready, cfg_data                  | cfg_valid and cfg_ready high
//
// A request keeps busy high while the scan reads each entry of the entry memory in turn,
// then while the last read is evaluated, and then while the block decides and writes back.
// The result strobe shows in the first cycle that busy is low, in which a new request may
// already be accepted. The single-port entry memory scan sets the busy time.
// Reset clears the live bits and sets the limit to 10; entry memory is not cleared.
// The receiver cannot stall; results are shown for exactly one cycle.
`timescale 1ns / 1ps

module named_timer_table
	import ntt_pkg::*;
#(
	parameter int unsigned TABLE_ENTRIES = 16,
	parameter int unsigned KEY_BITS      = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Request channel.
	input  logic                  start,
	output logic                  busy,
	input  logic                  kind,
	input  logic [31:0]           timer_key,
	input  logic [63:0]           timer_duration,
	input  logic [63:0]           current_time_ns,
	// Result channel.
	output logic                  result_valid,
	output logic [1:0]            start_status,
	output logic                  key_found,
	output logic [63:0]           timer_elapsed,
	output logic                  timer_expired,
	// Configuration channel.
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [LIMIT_BITS-1:0] cfg_data
);

	localparam int unsigned KW   = (KEY_BITS < 32) ? KEY_BITS : 32;
	localparam int unsigned IW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int unsigned CW   = $clog2(TABLE_ENTRIES + 1);
	localparam int unsigned CMPW = (CW > LIMIT_BITS) ? CW : LIMIT_BITS;
	localparam int unsigned EW   = KW + 128;

	// Entry word layout: key, start time, duration.
	localparam int unsigned DUR_LSB = 0;
	localparam int unsigned ST_LSB  = 64;
	localparam int unsigned KEY_LSB = 128;

	ntt_state_t state_q, state_d;

	logic [LIMIT_BITS-1:0]    limit_q;
	logic [TABLE_ENTRIES-1:0] live_q;
	logic [EW-1:0]            entry_mem [TABLE_ENTRIES];

	// Latched request.
	logic          kind_q;
	logic [KW-1:0] key_q;
	logic [63:0]   dur_q;
	logic [63:0]   now_q;

	// Scan pipeline.
	logic [IW-1:0] rd_idx_q;
	logic          rd_en;
	logic          scan_last;
	logic [EW-1:0] rd_s1;
	logic [IW-1:0] idx_s1;
	logic          valid_s1;

	// Scan accumulators.
	logic [CW-1:0] live_cnt_q;
	logic          free_found_q;
	logic [IW-1:0] free_idx_q;
	logic          dup_q;
	logic          hit_q;
	logic [63:0]   hit_elapsed_q;
	logic          hit_expired_q;

	// Evaluation of one entry read.
	logic [KW-1:0] rd_key;
	logic [63:0]   rd_start;
	logic [63:0]   rd_dur;
	logic [63:0]   rd_elapsed;
	logic          rd_expired;
	logic          rd_live;
	logic          rd_match;
	logic          rd_alive;

	logic accept;
	logic is_full;
	logic create;

	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	// Limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and sequencer outputs.
	always_comb begin
		state_d   = state_q;
		rd_en     = 1'b0;
		busy      = 1'b1;
		scan_last = (rd_idx_q == IW'(TABLE_ENTRIES - 1));
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				rd_en = 1'b1;
				if (scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			key_q  <= timer_key[KW-1:0];
			dur_q  <= timer_duration;
			now_q  <= current_time_ns;
		end
	end

	// Read address counter and read valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= rd_en;
			if (accept) begin
				rd_idx_q <= '0;
			end else if (rd_en && !scan_last) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
		end
	end

	// Decision at the end of the scan.
	assign is_full = (CMPW'(live_cnt_q) >= CMPW'(limit_q)) || !free_found_q;
	assign create  = (state_q == ST_FINISH) && (kind_q == KIND_START) && !is_full && !dup_q;

	// Entry memory: registered read during the scan, write of a new timer at the end.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_s1 <= entry_mem[rd_idx_q];
		end
		idx_s1 <= rd_idx_q;
		if (create) begin
			entry_mem[free_idx_q] <= {key_q, now_q, dur_q};
		end
	end

	// Evaluate the entry that came out of memory.
	assign rd_key     = rd_s1[KEY_LSB +: KW];
	assign rd_start   = rd_s1[ST_LSB +: 64];
	assign rd_dur     = rd_s1[DUR_LSB +: 64];
	assign rd_elapsed = now_q - rd_start;
	assign rd_expired = rd_elapsed > rd_dur;
	assign rd_live    = live_q[idx_s1];
	assign rd_match   = rd_live && (rd_key == key_q);
	assign rd_alive   = rd_live && !rd_expired;

	// Live bits and scan accumulators. Each entry is read once per scan, so the purge of
	// one entry never overlaps the read of the same entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q        <= '0;
			live_cnt_q    <= '0;
			free_found_q  <= 1'b0;
			free_idx_q    <= '0;
			dup_q         <= 1'b0;
			hit_q         <= 1'b0;
			hit_elapsed_q <= '0;
			hit_expired_q <= 1'b0;
		end else if (accept) begin
			live_cnt_q   <= '0;
			free_found_q <= 1'b0;
			dup_q        <= 1'b0;
			hit_q        <= 1'b0;
		end else if (valid_s1) begin
			if (kind_q == KIND_START) begin
				if (rd_live && rd_expired) begin
					live_q[idx_s1] <= 1'b0;
				end
				if (rd_alive) begin
					live_cnt_q <= live_cnt_q + 1'b1;
					if (rd_key == key_q) begin
						dup_q <= 1'b1;
					end
				end else if (!free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= idx_s1;
				end
			end else if (rd_match && !hit_q) begin
				hit_q         <= 1'b1;
				hit_elapsed_q <= rd_elapsed;
				hit_expired_q <= rd_expired;
			end
		end else if (create) begin
			live_q[free_idx_q] <= 1'b1;
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= (state_q == ST_FINISH);
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH) begin
			if (kind_q == KIND_START) begin
				if (is_full) begin
					start_status <= STATUS_FULL;
				end else if (dup_q) begin
					start_status <= STATUS_DUPLICATE;
				end else begin
					start_status <= STATUS_CREATED;
				end
				key_found     <= 1'b0;
				timer_elapsed <= '0;
				timer_expired <= 1'b0;
			end else begin
				start_status  <= STATUS_CREATED;
				key_found     <= hit_q;
				timer_elapsed <= hit_q ? hit_elapsed_q : 64'd0;
				timer_expired <= hit_q && hit_expired_q;
			end
		end
	end

endmodule

FILE: hw/rtl/ntt_port_checker.sv
`timescale 1ns / 1ps
`include "named_timer_table_assert.svh"

module ntt_port_checker
	import ntt_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        result_valid,
	input logic [1:0]  start_status,
	input logic        key_found,
	input logic [63:0] timer_elapsed,
	input logic        timer_expired
);

	logic fields_ok;

	// A hit reports created status; a miss or a start reports zero elapsed time, no expiry.
	assign fields_ok = key_found ? (start_status == STATUS_CREATED) :
		(timer_elapsed == 64'd0 && !timer_expired);

	// An accepted transaction keeps the block busy in the following cycle.
	`NTT_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "busy low after accept")

	// The result strobe lasts one cycle.
	`NTT_ASSERT_NEXT(a_strobe_single, clk, arst_n, result_valid, !result_valid, "strobe too long")

	// Busy only rises after a request was offered.
	`NTT_ASSERT(a_busy_cause, clk, arst_n, !$rose(busy) || $past(start), "busy rose unasked")

	// Result fields agree with each other.
	`NTT_ASSERT(a_result_fields, clk, arst_n, !result_valid || fields_ok, "inconsistent result")

endmodule

bind named_timer_table ntt_port_checker u_ntt_port_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.result_valid  (result_valid),
	.start_status  (start_status),
	.key_found     (key_found),
	.timer_elapsed (timer_elapsed),
	.timer_expired (timer_expired)
);

FILE: test/named_timer_table_test.sv
`timescale 1ns / 1ps

module named_timer_table_test;
	import ntt_pkg::*;

	localparam int unsigned TABLE_ENTRIES  = 16;
	localparam int unsigned KEY_POOL_SIZE  = 12;
	localparam int unsigned PHASE_ITEMS    = 48;
	localparam int unsigned SETTLE_CYCLES  = 4;
	localparam int unsigned WATCHDOG_LIMIT = 5000;

	// What one entry of the stimulus queue asks the driver to do.
	typedef enum logic [1:0] {
		STEP_REQUEST,
		STEP_LIMIT,
		STEP_QUIET
	} step_kind_t;

	typedef struct packed {
		step_kind_t            what;
		logic                  kind;
		logic [31:0]           key;
		logic [63:0]           dur;
		logic [63:0]           now;
		logic [LIMIT_BITS-1:0] limit;
	} pending_step_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        found;
		logic [63:0] elapsed;
		logic        expired;
	} timer_reply_t;

	// Block ports.
	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic                  kind = KIND_START;
	logic [31:0]           timer_key = '0;
	logic [63:0]           timer_duration = '0;
	logic [63:0]           current_time_ns = '0;
	logic                  result_valid;
	logic [1:0]            start_status;
	logic                  key_found;
	logic [63:0]           timer_elapsed;
	logic                  timer_expired;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [LIMIT_BITS-1:0] cfg_data = '0;

	// Shadow copy of the timer table and its limit register.
	logic                  table_live [TABLE_ENTRIES];
	logic [31:0]           table_key [TABLE_ENTRIES];
	logic [63:0]           table_start [TABLE_ENTRIES];
	logic [63:0]           table_dur [TABLE_ENTRIES];
	logic [LIMIT_BITS-1:0] limit_shadow = LIMIT_RESET;

	pending_step_t step_queue[$];
	timer_reply_t  expected_replies[$];

	int unsigned requests_issued = 0;
	int unsigned replies_seen = 0;
	int unsigned mismatches = 0;
	int unsigned stall_cycles = 0;
	int unsigned created_count = 0;
	int unsigned full_count = 0;
	int unsigned duplicate_count = 0;
	int unsigned check_count = 0;
	int unsigned found_count = 0;
	int unsigned expired_count = 0;
	int unsigned limit_settings = 1;

	named_timer_table #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.KEY_BITS(32)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.timer_key(timer_key),
		.timer_duration(timer_duration),
		.current_time_ns(current_time_ns),
		.result_valid(result_valid),
		.start_status(start_status),
		.key_found(key_found),
		.timer_elapsed(timer_elapsed),
		.timer_expired(timer_expired),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Applies one request to the shadow table and returns the reply it should produce.
	function automatic timer_reply_t timer_table_step(logic req_kind, logic [31:0] key,
		logic [63:0] dur, logic [63:0] now);
		timer_reply_t reply;
		int           live_count;
		int           free_slot;
		int           hit;
		logic [63:0]  age;

		reply = '0;
		hit = -1;
		if (req_kind == KIND_START) begin
			// Expired timers are freed before the table is examined.
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				age = now - table_start[i];
				if (table_live[i] && age > table_dur[i])
					table_live[i] = 1'b0;
			end
			live_count = 0;
			free_slot = -1;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (table_live[i])
					live_count++;
				else if (free_slot < 0)
					free_slot = i;
				if (table_live[i] && table_key[i] == key && hit < 0)
					hit = i;
			end
			if (live_count >= int'(limit_shadow) || free_slot < 0) begin
				reply.status = STATUS_FULL;
				full_count++;
			end else if (hit >= 0) begin
				reply.status = STATUS_DUPLICATE;
				duplicate_count++;
			end else begin
				table_live[free_slot] = 1'b1;
				table_key[free_slot] = key;
				table_start[free_slot] = now;
				table_dur[free_slot] = dur;
				reply.status = STATUS_CREATED;
				created_count++;
			end
		end else begin
			check_count++;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (table_live[i] && table_key[i] == key && hit < 0)
					hit = i;
			end
			if (hit >= 0) begin
				reply.found = 1'b1;
				reply.elapsed = now - table_start[hit];
				reply.expired = reply.elapsed > table_dur[hit];
				found_count++;
				if (reply.expired)
					expired_count++;
			end
		end
		return reply;
	endfunction

	task automatic queue_request(logic req_kind, logic [31:0] key, logic [63:0] dur,
		logic [63:0] now);
		pending_step_t s;

		s = '0;
		s.what = STEP_REQUEST;
		s.kind = req_kind;
		s.key = key;
		s.dur = dur;
		s.now = now;
		step_queue = {step_queue, s};
	endtask

	// Driver: issues requests in bursts and writes the limit only while the block is quiet.
	always @(posedge clk) begin : driver
		int unsigned   burst_left;
		int unsigned   gap_left;
		int unsigned   quiet_cycles;
		logic          next_start;
		logic          next_cfg_valid;
		pending_step_t head;
		timer_reply_t  reply_now;

		if (arst_n) begin
			next_start = start;
			next_cfg_valid = cfg_valid;

			// A request transaction completes at this edge.
			if (start && !busy) begin
				reply_now = timer_table_step(kind, timer_key, timer_duration,
					current_time_ns);
				expected_replies = {expected_replies, reply_now};
				requests_issued++;
				void'(step_queue.pop_front());
				next_start = 1'b0;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 20);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
				end
			end

			// A limit write completes at this edge.
			if (cfg_valid && cfg_ready) begin
				limit_shadow = cfg_data;
				limit_settings++;
				void'(step_queue.pop_front());
				next_cfg_valid = 1'b0;
			end

			if (replies_seen == requests_issued && !busy)
				quiet_cycles++;
			else
				quiet_cycles = 0;

			// Pick up the next step once nothing is in flight on either channel.
			if (!next_start && !next_cfg_valid && step_queue.size() > 0) begin
				head = step_queue[0];
				if (gap_left > 0) begin
					gap_left--;
				end else begin
					case (head.what)
						STEP_REQUEST: begin
							next_start = 1'b1;
							kind <= head.kind;
							timer_key <= head.key;
							timer_duration <= head.dur;
							current_time_ns <= head.now;
						end
						STEP_LIMIT: begin
							if (quiet_cycles >= SETTLE_CYCLES) begin
								next_cfg_valid = 1'b1;
								cfg_data <= head.limit;
							end
						end
						default: begin
							if (quiet_cycles >= SETTLE_CYCLES)
								void'(step_queue.pop_front());
						end
					endcase
				end
			end

			start <= next_start;
			cfg_valid <= next_cfg_valid;
		end else begin
			burst_left = 1;
			gap_left = 0;
			quiet_cycles = 0;
		end
	end

	// Monitor: every strobed result is compared with the oldest expected reply.
	always @(posedge clk) begin : monitor
		timer_reply_t want;

		if (arst_n && result_valid) begin
			if (expected_replies.size() == 0) begin
				$error("result with no request outstanding: status %0d found %0d",
					start_status, key_found);
				mismatches++;
			end else begin
				want = expected_replies.pop_front();
				if (start_status !== want.status) begin
					$error("start_status: expected %0d, got %0d", want.status, start_status);
					mismatches++;
				end
				if (key_found !== want.found) begin
					$error("key_found: expected %0d, got %0d", want.found, key_found);
					mismatches++;
				end
				if (timer_elapsed !== want.elapsed) begin
					$error("timer_elapsed: expected %h, got %h", want.elapsed, timer_elapsed);
					mismatches++;
				end
				if (timer_expired !== want.expired) begin
					$error("timer_expired: expected %0d, got %0d", want.expired, timer_expired);
					mismatches++;
				end
			end
			replies_seen <= replies_seen + 1;
		end
	end

	// Count cycles in which no transaction of any kind completes.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		while (stall_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("named_timer_table: mismatch");
		$finish;
	end

	initial begin : stimulus
		logic [31:0]           key_pool [KEY_POOL_SIZE];
		logic [LIMIT_BITS-1:0] phase_limits [8];
		logic [63:0]           base_ns;
		logic [63:0]           item_now;
		logic [63:0]           item_dur;
		logic [31:0]           item_key;
		logic                  item_kind;
		pending_step_t         s;
		int unsigned           roll;

		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			table_live[i] = 1'b0;
			table_key[i] = '0;
			table_start[i] = '0;
			table_dur[i] = '0;
		end

		// Directed part, under the reset limit of ten.
		queue_request(KIND_CHECK, 32'd0, 64'd0, 64'd0);
		queue_request(KIND_START, 32'd0, 64'd100, 64'd0);
		queue_request(KIND_START, 32'd0, 64'd5, 64'd10);
		queue_request(KIND_CHECK, 32'd0, 64'd0, 64'd50);
		// Elapsed equal to the duration is not expired; one more tick is.
		queue_request(KIND_CHECK, 32'd0, 64'd0, 64'd100);
		queue_request(KIND_CHECK, 32'd0, 64'd0, 64'd101);
		// A check never frees an expired entry.
		queue_request(KIND_CHECK, 32'd0, 64'd0, 64'd101);
		queue_request(KIND_START, 32'hFFFF_FFFF, 64'd500, 64'd101);
		queue_request(KIND_CHECK, 32'd0, 64'd0, 64'd102);
		for (int i = 1; i <= 9; i++)
			queue_request(KIND_START, 32'(i), 64'd1000, 64'd102);
		// Table at its limit and key already live: full wins.
		queue_request(KIND_START, 32'hFFFF_FFFF, '1, 64'd102);
		// Time running backwards wraps the elapsed value.
		queue_request(KIND_CHECK, 32'hFFFF_FFFF, '1, 64'd0);
		queue_request(KIND_START, 32'h5A5A_5A5A, 64'd0, '1);
		queue_request(KIND_CHECK, 32'h5A5A_5A5A, 64'd0, '1);

		// Random part: one phase per limit setting, extremes included.
		phase_limits = '{LIMIT_RESET, 5'd0, 5'd1, 5'd31, 5'd16, 5'd3,
			5'($urandom_range(2, 15)), LIMIT_RESET};
		key_pool[0] = 32'd0;
		key_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < 6; i++)
			key_pool[i] = $urandom;
		for (int i = 6; i < KEY_POOL_SIZE; i++)
			key_pool[i] = 32'(i);
		base_ns = 64'd1000;

		for (int p = 0; p < 8; p++) begin
			if (p > 0) begin
				s = '0;
				s.what = STEP_LIMIT;
				s.limit = phase_limits[p];
				step_queue = {step_queue, s};
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Let all outstanding requests finish once in the middle of a phase.
				if (p == 4 && n == PHASE_ITEMS / 2) begin
					s = '0;
					s.what = STEP_QUIET;
					step_queue = {step_queue, s};
				end
				if ($urandom_range(0, 99) < 3)
					base_ns = {$urandom, $urandom};
				else
					base_ns += 64'($urandom_range(0, 300));
				item_now = base_ns;
				if ($urandom_range(0, 99) < 4)
					item_now = base_ns - 64'($urandom_range(1, 500));
				item_kind = ($urandom_range(0, 99) < 55) ? KIND_START : KIND_CHECK;
				item_key = ($urandom_range(0, 99) < 85) ?
					key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)] : $urandom;
				roll = $urandom_range(0, 99);
				if (roll < 10)
					item_dur = 64'd0;
				else if (roll < 20)
					item_dur = {$urandom, $urandom};
				else
					item_dur = 64'($urandom_range(0, 2000));
				queue_request(item_kind, item_key, item_dur, item_now);
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every step to be taken and every reply to come back.
		while (step_queue.size() != 0 || replies_seen != requests_issued)
			@(posedge clk);
		repeat (TABLE_ENTRIES + 8) @(posedge clk);

		if (expected_replies.size() != 0) begin
			$error("%0d expected replies never arrived", expected_replies.size());
			mismatches++;
		end

		$display("Ran %0d requests over %0d limit settings: %0d created, %0d full, %0d duplicate.",
			requests_issued, limit_settings, created_count, full_count, duplicate_count);
		$display("Checks: %0d issued, %0d found, %0d of those expired.",
			check_count, found_count, expired_count);
		if (mismatches == 0)
			$display("named_timer_table: match");
		else
			$display("named_timer_table: mismatch");
		$finish;
	end

endmodule
